[src/uart_tr_pkg.sv]
package uart_tr_pkg;

    localparam int unsigned DIV_W         = 16;
    localparam int unsigned CNT_W         = 4;
    localparam int unsigned SEND_SHIFT_W  = 9;
    localparam int unsigned RECV_SHIFT_W  = 10;
    localparam int unsigned APB_DATA_W    = 32;
    localparam int unsigned APB_ADDR_W    = 3;

    localparam logic [DIV_W-1:0] DIVISOR_RESET  = 16'd434;
    localparam logic [CNT_W-1:0] FRAME_BITS     = 4'd10;
    localparam logic             REG_BIT_DIVISOR = 1'b0;

    typedef struct packed {
        logic       tx_line;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       framing_error;
        logic       tx_busy;
        logic       push_dropped;
    } t_result;

endpackage

[src/uart_transceiver_8n1.sv]
// throughput: one tick request per cycle while o_in_stall is low
// all tick logic sits between the state and result registers
// a two-entry output stage (register plus skid) keeps input taken while a result waits
// synchronous active-low reset: both serial engines idle, tx line register high, queue empty,
// held byte zero, bit divisor 434; queue storage is not cleared
module uart_transceiver_8n1 #(
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_rx_line,
    input  logic                                i_push_valid,
    input  logic [7:0]                          i_push_byte,

    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_tx_line,
    output logic                                o_rx_valid,
    output logic [7:0]                          o_rx_byte,
    output logic                                o_framing_error,
    output logic                                o_tx_busy,
    output logic                                o_push_dropped,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [uart_tr_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [uart_tr_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [uart_tr_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                pready
);

    localparam int unsigned PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned SUM_W  = FILL_W + 1;
    localparam int unsigned DIV_W  = uart_tr_pkg::DIV_W;
    localparam int unsigned CNT_W  = uart_tr_pkg::CNT_W;
    localparam int unsigned STX_W  = uart_tr_pkg::SEND_SHIFT_W;
    localparam int unsigned SRX_W  = uart_tr_pkg::RECV_SHIFT_W;

    // configuration
    logic [DIV_W-1:0] r_bit_divisor;
    logic             cfg_wr;

    // transmitter and queue
    logic             r_send_active, n_send_active;
    logic [DIV_W-1:0] r_send_timer,  n_send_timer;
    logic [STX_W-1:0] r_send_shift,  n_send_shift;
    logic [CNT_W-1:0] r_send_cnt,    n_send_cnt;
    logic             r_line_out,    n_line_out;
    logic [PTR_W-1:0] r_head,        n_head;
    logic [FILL_W-1:0] r_fill,       n_fill;
    logic [7:0]       r_head_byte;
    logic [7:0]       r_queue [QUEUE_DEPTH];

    // receiver
    logic             r_recv_active, n_recv_active;
    logic [DIV_W-1:0] r_recv_timer,  n_recv_timer;
    logic [SRX_W-1:0] r_recv_shift,  n_recv_shift;
    logic [CNT_W-1:0] r_recv_cnt,    n_recv_cnt;
    logic [7:0]       r_held_byte,   n_held_byte;

    // output stage
    uart_tr_pkg::t_result res, r_out, r_skd;
    logic             r_out_valid, r_skd_valid;
    logic             in_fire, out_fire;

    logic             wr_ok, pop, rx_good, rx_bad;
    logic [FILL_W-1:0] fill_a;
    logic [SUM_W-1:0] wsum;
    logic [PTR_W-1:0] waddr;
    logic [7:0]       pop_byte;
    logic [DIV_W-1:0] send_dec, recv_dec;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite
                    && (paddr[2] == uart_tr_pkg::REG_BIT_DIVISOR);
    assign prdata = (paddr[2] == uart_tr_pkg::REG_BIT_DIVISOR)
                    ? {{(uart_tr_pkg::APB_DATA_W - DIV_W){1'b0}}, r_bit_divisor}
                    : '0;

    assign in_fire  = i_in_valid && !r_skd_valid;
    assign out_fire = r_out_valid && !i_out_stall;
    assign o_in_stall = r_skd_valid;

    always_comb begin
        // queue push
        wr_ok  = i_push_valid && (r_fill < FILL_W'(QUEUE_DEPTH));
        fill_a = r_fill + FILL_W'(wr_ok);
        wsum   = SUM_W'(r_head) + SUM_W'(r_fill);
        if (wsum >= SUM_W'(QUEUE_DEPTH)) begin
            wsum = wsum - SUM_W'(QUEUE_DEPTH);
        end
        waddr    = PTR_W'(wsum);
        pop_byte = (r_fill != '0) ? r_head_byte : i_push_byte;

        // transmitter
        n_send_active = r_send_active;
        n_send_timer  = r_send_timer;
        n_send_shift  = r_send_shift;
        n_send_cnt    = r_send_cnt;
        n_line_out    = r_line_out;
        send_dec      = r_send_timer - DIV_W'(1);
        pop           = !r_send_active && (fill_a != '0);
        if (!r_send_active) begin
            if (pop) begin
                n_line_out    = 1'b0;
                n_send_active = 1'b1;
                n_send_timer  = r_bit_divisor;
                n_send_shift  = {1'b1, pop_byte};
                n_send_cnt    = '0;
            end
        end else begin
            n_send_timer = send_dec;
            if (send_dec == '0) begin
                n_send_timer = r_bit_divisor;
                n_line_out   = r_send_shift[0];
                n_send_shift = {1'b0, r_send_shift[STX_W-1:1]};
                n_send_cnt   = r_send_cnt + CNT_W'(1);
                if (n_send_cnt == uart_tr_pkg::FRAME_BITS) begin
                    n_line_out    = 1'b1;
                    n_send_active = 1'b0;
                end
            end
        end

        if (pop) begin
            n_head = (r_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_head + PTR_W'(1);
        end else begin
            n_head = r_head;
        end
        n_fill = fill_a - FILL_W'(pop);

        // receiver
        n_recv_active = r_recv_active;
        n_recv_timer  = r_recv_timer;
        n_recv_shift  = r_recv_shift;
        n_recv_cnt    = r_recv_cnt;
        n_held_byte   = r_held_byte;
        rx_good       = 1'b0;
        rx_bad        = 1'b0;
        recv_dec      = r_recv_timer - DIV_W'(1);
        if (!r_recv_active) begin
            if (!i_rx_line) begin
                n_recv_active = 1'b1;
                n_recv_timer  = r_bit_divisor >> 1;
                n_recv_shift  = '0;
                n_recv_cnt    = '0;
            end
        end else begin
            n_recv_timer = recv_dec;
            if (recv_dec == '0) begin
                n_recv_timer = r_bit_divisor;
                n_recv_shift = {r_recv_shift[SRX_W-2:0], i_rx_line};
                n_recv_cnt   = r_recv_cnt + CNT_W'(1);
                if (n_recv_cnt == uart_tr_pkg::FRAME_BITS) begin
                    n_recv_active = 1'b0;
                    if (n_recv_shift[SRX_W-1] || !n_recv_shift[0]) begin
                        rx_bad = 1'b1;
                    end else begin
                        rx_good = 1'b1;
                        // first sampled data bit is the lsb
                        for (int j = 0; j < 8; j++) begin
                            n_held_byte[j] = n_recv_shift[8-j];
                        end
                    end
                end
            end
        end

        res.tx_line       = n_line_out;
        res.rx_valid      = rx_good;
        res.rx_byte       = n_held_byte;
        res.framing_error = rx_bad;
        res.tx_busy       = n_send_active || (n_fill != '0);
        res.push_dropped  = i_push_valid && !wr_ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_divisor <= uart_tr_pkg::DIVISOR_RESET;
        end else if (cfg_wr) begin
            r_bit_divisor <= pwdata[DIV_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && wr_ok) begin
            r_queue[waddr] <= i_push_byte;
        end
        if (in_fire) begin
            // keep the entry at the queue head in a register
            if (wr_ok && (waddr == n_head)) begin
                r_head_byte <= i_push_byte;
            end else begin
                r_head_byte <= r_queue[n_head];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_send_active <= 1'b0;
            r_send_timer  <= '0;
            r_send_shift  <= '0;
            r_send_cnt    <= '0;
            r_line_out    <= 1'b1;
            r_head        <= '0;
            r_fill        <= '0;
            r_recv_active <= 1'b0;
            r_recv_timer  <= '0;
            r_recv_shift  <= '0;
            r_recv_cnt    <= '0;
            r_held_byte   <= '0;
        end else if (in_fire) begin
            r_send_active <= n_send_active;
            r_send_timer  <= n_send_timer;
            r_send_shift  <= n_send_shift;
            r_send_cnt    <= n_send_cnt;
            r_line_out    <= n_line_out;
            r_head        <= n_head;
            r_fill        <= n_fill;
            r_recv_active <= n_recv_active;
            r_recv_timer  <= n_recv_timer;
            r_recv_shift  <= n_recv_shift;
            r_recv_cnt    <= n_recv_cnt;
            r_held_byte   <= n_held_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skd_valid <= 1'b0;
        end else begin
            if (in_fire && (!r_out_valid || out_fire)) begin
                r_out_valid <= 1'b1;
            end else if (in_fire) begin
                r_skd_valid <= 1'b1;
            end else if (out_fire) begin
                r_out_valid <= r_skd_valid;
                r_skd_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && (!r_out_valid || out_fire)) begin
            r_out <= res;
        end else if (in_fire) begin
            r_skd <= res;
        end else if (out_fire && r_skd_valid) begin
            r_out <= r_skd;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_tx_line       = r_out.tx_line;
    assign o_rx_valid      = r_out.rx_valid;
    assign o_rx_byte       = r_out.rx_byte;
    assign o_framing_error = r_out.framing_error;
    assign o_tx_busy       = r_out.tx_busy;
    assign o_push_dropped  = r_out.push_dropped;

endmodule
